[rtl/mandel_pkg.sv]
// ============================================================================
// mandel_pkg
// Shared types, constants and helpers for the Mandelbrot escape-time block.
// ============================================================================
package mandel_pkg;

    // Signed Q4.28 point coordinates.
    localparam int Q_W      = 32;
    localparam int FRAC     = 28;
    // Pixel index width and image size along each axis.
    localparam int IDX_W    = 9;
    localparam int PIXELS   = 512;
    localparam int CNT_W    = 16;
    // Exact products of two Q4.28 values.
    localparam int PROD_W   = 2 * Q_W;
    // Width that holds every pre-saturation sum in the design.
    localparam int SUM_W    = 42;
    // Escape threshold 4.0 in Q8.56 is 2^58: escape when any bit above 57 is set.
    localparam int ESC_BIT  = 2 * FRAC + 2;

    // Recirculating iteration ring.
    localparam int RING_DEPTH = 4;
    localparam int TAG_W      = $clog2(RING_DEPTH);

    // Configuration register map.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_REAL  = 3'd0,
        REG_MIN_IMAG  = 3'd1,
        REG_STEP_REAL = 3'd2,
        REG_STEP_IMAG = 3'd3,
        REG_MAX_ITER  = 3'd4
    } cfg_reg_t;

    localparam logic signed [Q_W-1:0] MIN_REAL_RST  = -32'sd536870912;
    localparam logic signed [Q_W-1:0] MIN_IMAG_RST  = -32'sd322122547;
    localparam logic signed [Q_W-1:0] STEP_REAL_RST = 32'sd1572864;
    localparam logic signed [Q_W-1:0] STEP_IMAG_RST = 32'sd1572864;
    localparam logic [CNT_W-1:0]      MAX_ITER_RST  = 16'd2000;

    // A mapped point entering the iteration ring.
    typedef struct packed {
        logic signed [Q_W-1:0] cr;
        logic signed [Q_W-1:0] ci;
        logic [IDX_W-1:0]      x;
        logic [IDX_W-1:0]      y;
    } point_t;

    // A finished pixel leaving the ring.
    typedef struct packed {
        logic [IDX_W-1:0] x;
        logic [IDX_W-1:0] y;
        logic [CNT_W-1:0] cnt;
    } result_t;

    // Clamp a wide signed sum to the Q4.28 range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v[SUM_W-1] && !(&v[SUM_W-2:Q_W-1])) begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end else if (!v[SUM_W-1] && (|v[SUM_W-2:Q_W-1])) begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/mandel_ring.sv]
// ============================================================================
// mandel_ring
// Four-stage recirculating pipeline that runs z = z*z + c for up to four
// pixels at once and releases finished pixels in arrival order.
// ============================================================================
module mandel_ring
    import mandel_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] max_iter,
    input  logic             in_valid,
    output logic             in_ready,
    input  point_t           in_point,
    output logic             out_valid,
    input  logic             out_free,
    output result_t          out_result
);

    typedef struct packed {
        logic signed [Q_W-1:0] zr;
        logic signed [Q_W-1:0] zi;
        logic signed [Q_W-1:0] cr;
        logic signed [Q_W-1:0] ci;
        logic [CNT_W-1:0]      cnt;
        logic [TAG_W-1:0]      tag;
        logic [IDX_W-1:0]      x;
        logic [IDX_W-1:0]      y;
        logic                  done;
    } slot_t;

    slot_t s0_reg, s0_next, s1_reg, s2_reg, s2_next, s3_reg, s3_next;
    logic  v0_reg, v0_next, v1_reg, v2_reg, v3_reg;
    logic signed [PROD_W-1:0] prr_reg, pii_reg, pri_reg, pri2_reg, diff_reg;
    logic  iter_reg, iter_next;
    logic [TAG_W-1:0] in_seq_reg, out_seq_reg;

    logic [PROD_W-1:0] mag;
    logic signed [PROD_W-1:0] diff;
    logic  exit_now, slot_free, insert;
    slot_t new_slot;

    // Stage 1: magnitude test and difference of squares.
    always_comb begin
        mag       = prr_reg + pii_reg;
        diff      = prr_reg - pii_reg;
        iter_next = !s1_reg.done && (s1_reg.cnt < max_iter) && !(|mag[PROD_W-1:ESC_BIT]);
        s2_next   = s1_reg;
        if (!s1_reg.done && !iter_next) begin
            s2_next.done = 1'b1;
        end
        if (iter_next) begin
            s2_next.cnt = s1_reg.cnt + 1'b1;
        end
    end

    // Stage 2: floor back to Q4.28, add c and clamp.
    always_comb begin
        s3_next = s2_reg;
        if (iter_reg) begin
            s3_next.zr = sat_q(SUM_W'($signed(diff_reg[PROD_W-1:FRAC])) + SUM_W'(s2_reg.cr));
            s3_next.zi = sat_q(SUM_W'($signed(pri2_reg[PROD_W-1:FRAC-1]))
                               + SUM_W'(s2_reg.ci));
        end
    end

    // Stage 3 to stage 0: retire the oldest pixel once it is finished, or
    // insert a new pixel into the empty slot.
    always_comb begin
        exit_now  = v3_reg && s3_reg.done && (s3_reg.tag == out_seq_reg) && out_free;
        slot_free = !v3_reg || exit_now;
        insert    = slot_free && in_valid;

        new_slot      = '0;
        new_slot.zr   = in_point.cr;
        new_slot.zi   = in_point.ci;
        new_slot.cr   = in_point.cr;
        new_slot.ci   = in_point.ci;
        new_slot.tag  = in_seq_reg;
        new_slot.x    = in_point.x;
        new_slot.y    = in_point.y;

        s0_next = insert ? new_slot : s3_reg;
        v0_next = insert || (v3_reg && !exit_now);
    end

    assign in_ready       = slot_free;
    assign out_valid      = exit_now;
    assign out_result.x   = s3_reg.x;
    assign out_result.y   = s3_reg.y;
    assign out_result.cnt = s3_reg.cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            in_seq_reg  <= '0;
            out_seq_reg <= '0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (insert) begin
                in_seq_reg <= in_seq_reg + 1'b1;
            end
            if (exit_now) begin
                out_seq_reg <= out_seq_reg + 1'b1;
            end
        end
    end

    // Payload moves every cycle; the valid bits say which slots hold pixels.
    always_ff @(posedge aclk) begin
        s0_reg   <= s0_next;
        s1_reg   <= s0_reg;
        prr_reg  <= PROD_W'(s0_reg.zr) * PROD_W'(s0_reg.zr);
        pii_reg  <= PROD_W'(s0_reg.zi) * PROD_W'(s0_reg.zi);
        pri_reg  <= PROD_W'(s0_reg.zr) * PROD_W'(s0_reg.zi);
        s2_reg   <= s2_next;
        iter_reg <= iter_next;
        diff_reg <= diff;
        pri2_reg <= pri_reg;
        s3_reg   <= s3_next;
    end

endmodule

[rtl/mandelbrot_escape_time.sv]
// ============================================================================
// mandelbrot_escape_time
// Escape-time counter for one pixel of the Mandelbrot set in Q4.28.
// ============================================================================
// Each request names a pixel by column and row. A two-stage front end maps it
// to c = min + index*step (one multiply stage, one add-and-clamp stage). The
// point then joins a four-stage recirculating ring: multiply, magnitude test,
// rescale-add-clamp, and a retire/insert stage. Each iteration of z = z*z + c
// makes one full pass through the ring, and up to four pixels share the ring,
// one per stage. Results leave in request order: a finished pixel keeps
// circling until all older pixels have left and the output register is free,
// which adds to its latency. The output register lets the ring keep running
// while a result waits on m_ready. Configuration writes are taken every cycle
// and must only happen while no request is in flight.
// ============================================================================
module mandelbrot_escape_time
    import mandel_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]       cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IDX_W-1:0]     s_x_index,
    input  logic [IDX_W-1:0]     s_y_index,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_W-1:0]     m_pixel_x,
    output logic [IDX_W-1:0]     m_pixel_y,
    output logic [CNT_W-1:0]     m_iteration_count
);

    // Configuration registers.
    logic signed [Q_W-1:0] min_real_reg, min_imag_reg, step_real_reg, step_imag_reg;
    logic [CNT_W-1:0]      max_iter_reg;

    // Mapping stage A holds the products, stage B the clamped point.
    logic                    a_valid_reg, b_valid_reg;
    logic signed [SUM_W-1:0] a_px_reg, a_py_reg;
    logic [IDX_W-1:0]        a_x_reg, a_y_reg;
    point_t                  b_point_reg;
    logic                    a_move, b_take, s_take;
    logic [IDX_W-1:0]        x_red, y_red;

    // Ring connection and output register.
    logic    ring_ready, ring_out_valid, out_free;
    result_t ring_result;
    logic    m_valid_reg;
    result_t m_result_reg;

    assign cfg_ready = 1'b1;

    // The configuration port accepts every write; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_real_reg  <= MIN_REAL_RST;
            min_imag_reg  <= MIN_IMAG_RST;
            step_real_reg <= STEP_REAL_RST;
            step_imag_reg <= STEP_IMAG_RST;
            max_iter_reg  <= MAX_ITER_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MIN_REAL:  min_real_reg  <= cfg_data;
                REG_MIN_IMAG:  min_imag_reg  <= cfg_data;
                REG_STEP_REAL: step_real_reg <= cfg_data;
                REG_STEP_IMAG: step_imag_reg <= cfg_data;
                REG_MAX_ITER:  max_iter_reg  <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Indexes wrap at the image size; with a full-width index this is a no-op.
    assign x_red = IDX_W'(s_x_index % PIXELS);
    assign y_red = IDX_W'(s_y_index % PIXELS);

    // Elastic front end: a stage moves on when the one after it is empty or
    // is handing its point over in the same cycle.
    assign b_take  = b_valid_reg && ring_ready;
    assign a_move  = a_valid_reg && (!b_valid_reg || b_take);
    assign s_ready = !a_valid_reg || a_move;
    assign s_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (!b_valid_reg || b_take) begin
                b_valid_reg <= a_move;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            a_px_reg <= SUM_W'($signed({1'b0, x_red})) * SUM_W'(step_real_reg);
            a_py_reg <= SUM_W'($signed({1'b0, y_red})) * SUM_W'(step_imag_reg);
            a_x_reg  <= x_red;
            a_y_reg  <= y_red;
        end
        if (a_move) begin
            b_point_reg.cr <= sat_q(SUM_W'(min_real_reg) + a_px_reg);
            b_point_reg.ci <= sat_q(SUM_W'(min_imag_reg) + a_py_reg);
            b_point_reg.x  <= a_x_reg;
            b_point_reg.y  <= a_y_reg;
        end
    end

    mandel_ring u_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .max_iter   (max_iter_reg),
        .in_valid   (b_valid_reg),
        .in_ready   (ring_ready),
        .in_point   (b_point_reg),
        .out_valid  (ring_out_valid),
        .out_free   (out_free),
        .out_result (ring_result)
    );

    // The output register is free when empty or when its result is taken now.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= ring_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && ring_out_valid) begin
            m_result_reg <= ring_result;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pixel_x         = m_result_reg.x;
    assign m_pixel_y         = m_result_reg.y;
    assign m_iteration_count = m_result_reg.cnt;

endmodule

[rtl/mandel_checker.sv]
// ============================================================================
// mandel_checker
// Port-level checks for the escape-time block, bound to the top level.
// ============================================================================
module mandel_checker
    import mandel_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [Q_W-1:0]       cfg_data,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [IDX_W-1:0]     m_pixel_x,
    input logic [IDX_W-1:0]     m_pixel_y,
    input logic [CNT_W-1:0]     m_iteration_count
);

    // Two mapping stages, the ring and the output register.
    localparam int MAX_INFLIGHT = RING_DEPTH + 3;
    localparam int OUT_W        = $clog2(MAX_INFLIGHT + 2);

    logic [CNT_W-1:0] limit_reg;
    logic [OUT_W-1:0] pending_reg;
    logic             in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= MAX_ITER_RST;
            pending_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready && cfg_index == REG_MAX_ITER) begin
                limit_reg <= cfg_data[CNT_W-1:0];
            end
            pending_reg <= pending_reg + OUT_W'(in_acc) - OUT_W'(out_acc);
        end
    end

    // A waiting result holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_x) && $stable(m_pixel_y)
                                && $stable(m_iteration_count))
        else $error("result changed while stalled");

    // Every result belongs to an earlier request.
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> pending_reg != '0)
        else $error("result without a pending request");

    // No more requests are in flight than the pipeline has room for.
    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= OUT_W'(MAX_INFLIGHT))
        else $error("too many requests in flight");

    // The count never passes the iteration limit.
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_iteration_count <= limit_reg)
        else $error("iteration count above limit");

endmodule

bind mandelbrot_escape_time mandel_checker u_mandel_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_pixel_x         (m_pixel_x),
    .m_pixel_y         (m_pixel_y),
    .m_iteration_count (m_iteration_count)
);
